/* rtl/dwvs_pkg.sv */
// Package for the degree-weighted vertex sampler: sizes, status codes and
// controller states. No dependencies.
package dwvs_pkg;
    localparam int VertexCount   = 4096;
    localparam int BlockVertices = 64;
    localparam int BlockCount    = 64;
    localparam int VW = $clog2(VertexCount);
    localparam int OW = $clog2(BlockVertices);
    localparam int BW = $clog2(BlockCount);
    localparam int DW = 32;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FAIL  = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_ADD_RD, S_ADD_WA, S_ADD_RB, S_ADD_WB, S_DIV, S_BRD, S_BCHK,
        S_VRD, S_VCHK, S_OUT
    } t_state;
endpackage

/* rtl/dwvs_mod64.sv */
// Restoring 64 by 32 bit remainder unit, one quotient bit per cycle.
// Depends on dwvs_pkg.
module dwvs_mod64 (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [63:0]            i_dividend,
    input  logic [dwvs_pkg::DW-1:0] i_divisor,
    output logic                   o_done,
    output logic [dwvs_pkg::DW-1:0] o_rem
);
    logic [63:0] r_num, n_num;
    logic [31:0] r_rem, n_rem;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic [32:0] w_try;

    always_comb begin
        n_num  = r_num;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        w_try  = {r_rem, r_num[63]};
        if (i_start) begin
            n_num  = i_dividend;
            n_rem  = '0;
            n_cnt  = 7'd64;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_num = {r_num[62:0], 1'b0};
            // The partial remainder stays below the divisor, so 32 bits hold it.
            if (w_try >= {1'b0, i_divisor}) n_rem = w_try[31:0] - i_divisor;
            else n_rem = w_try[31:0];
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num <= n_num;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
        if (!i_rst_n) r_busy <= 1'b0;
        else r_busy <= n_busy;
    end

    assign o_done = r_busy && (r_cnt == 7'd1) && !i_start;
    assign o_rem  = n_rem;
endmodule

/* rtl/dwvs_store.sv */
// Degree memories: vertex degrees and block sums, registered reads,
// with a clearing pass after reset. Depends on dwvs_pkg.
module dwvs_store (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    output logic                          o_clearing,
    input  logic [dwvs_pkg::VW-1:0]       i_v_addr,
    input  logic                          i_v_we,
    input  logic [dwvs_pkg::DW-1:0]       i_v_wdata,
    output logic [dwvs_pkg::DW-1:0]       o_v_rdata,
    input  logic [dwvs_pkg::BW-1:0]       i_b_addr,
    input  logic                          i_b_we,
    input  logic [dwvs_pkg::DW-1:0]       i_b_wdata,
    output logic [dwvs_pkg::DW-1:0]       o_b_rdata
);
    logic [dwvs_pkg::DW-1:0] r_vmem [dwvs_pkg::VertexCount];
    logic [dwvs_pkg::DW-1:0] r_bmem [dwvs_pkg::BlockCount];
    logic [dwvs_pkg::VW:0]   r_clr;
    logic                    w_clr;

    assign w_clr      = !r_clr[dwvs_pkg::VW];
    assign o_clearing = w_clr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_clr <= '0;
        else if (w_clr) r_clr <= r_clr + 1'b1;
    end

    // The clearing pass sweeps both memories by the same counter.
    always_ff @(posedge i_clk) begin
        if (w_clr) r_vmem[r_clr[dwvs_pkg::VW-1:0]] <= '0;
        else if (i_v_we) r_vmem[i_v_addr] <= i_v_wdata;
        o_v_rdata <= r_vmem[i_v_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_clr) r_bmem[r_clr[dwvs_pkg::BW-1:0]] <= '0;
        else if (i_b_we) r_bmem[i_b_addr] <= i_b_wdata;
        o_b_rdata <= r_bmem[i_b_addr];
    end
endmodule

/* rtl/degree_weighted_vertex_sampler_top.sv */
// Top level of the degree-weighted vertex sampler: controller, memories and
// remainder unit. Depends on dwvs_pkg, dwvs_store and dwvs_mod64.
//
//  channel  dir  tdata (low bit first)                        tuser
//  s_axis   in   vertex_a[11:0] vertex_b[23:12] rnd[87:24]   mode
//  m_axis   out  low[11:0] high[23:12] added[24] sampled[36:25] status[38:37]
//
// An add passes from one input transfer to the next through a read and a
// write-back for each endpoint, the result state and the idle state; a self loop
// or a full total goes from the first read straight to the result. A sample
// waits for the remainder, then reads and checks each block and each vertex
// visited, then the result and idle states; an empty total goes straight to the
// result. After reset a clearing pass runs before the first transfer.
// One item is in work at a time; s_axis_tready is low until the result leaves.
module degree_weighted_vertex_sampler_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,   // vertex_a, vertex_b, random_value
    input  logic        s_axis_tuser,   // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // low, high, added, sampled, status, pad
);
    localparam int VW = dwvs_pkg::VW;
    localparam int DW = dwvs_pkg::DW;

    dwvs_pkg::t_state r_state, n_state;
    logic [VW-1:0] r_lo, r_hi, r_pick;
    logic [63:0]   r_rnd;
    logic [DW-1:0] r_total, r_target;
    logic [32:0]   r_run;
    logic [dwvs_pkg::BW-1:0] r_blk;
    logic [dwvs_pkg::OW-1:0] r_off;
    logic          r_added;
    dwvs_pkg::t_status r_status;
    logic          r_mod_start;

    logic clearing, mod_start, mod_done;
    logic [DW-1:0] mod_rem, v_rdata, b_rdata;
    logic [VW-1:0] v_addr;
    logic [dwvs_pkg::BW-1:0] b_addr;
    logic v_we, b_we;
    logic [32:0] w_next_b, w_next_v;
    logic [VW-1:0] a_in, b_in;
    logic          w_acc;

    assign a_in  = s_axis_tdata[VW-1:0];
    assign b_in  = s_axis_tdata[2*VW-1:VW];
    assign w_acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == dwvs_pkg::S_IDLE) && !clearing;
    assign m_axis_tvalid = (r_state == dwvs_pkg::S_OUT);
    assign m_axis_tdata  = {1'b0, r_status, r_pick, r_added, r_hi, r_lo};
    assign w_next_b = r_run + {1'b0, b_rdata};
    assign w_next_v = r_run + {1'b0, v_rdata};
    assign mod_start = r_mod_start;

    dwvs_store u_store (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .o_clearing(clearing),
        .i_v_addr(v_addr), .i_v_we(v_we), .i_v_wdata(v_rdata + 32'd1),
        .o_v_rdata(v_rdata),
        .i_b_addr(b_addr), .i_b_we(b_we), .i_b_wdata(b_rdata + 32'd1),
        .o_b_rdata(b_rdata)
    );

    dwvs_mod64 u_mod (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mod_start),
        .i_dividend(r_rnd), .i_divisor(r_total), .o_done(mod_done), .o_rem(mod_rem)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dwvs_pkg::S_IDLE: if (w_acc) begin
                if (s_axis_tuser) n_state = dwvs_pkg::S_DIV;
                else n_state = dwvs_pkg::S_ADD_RD;
            end
            dwvs_pkg::S_ADD_RD: begin
                if (r_lo == r_hi || r_total > 32'hFFFF_FFFD) n_state = dwvs_pkg::S_OUT;
                else n_state = dwvs_pkg::S_ADD_WA;
            end
            dwvs_pkg::S_ADD_WA: n_state = dwvs_pkg::S_ADD_RB;
            dwvs_pkg::S_ADD_RB: n_state = dwvs_pkg::S_ADD_WB;
            dwvs_pkg::S_ADD_WB: n_state = dwvs_pkg::S_OUT;
            dwvs_pkg::S_DIV: begin
                if (r_total == '0) n_state = dwvs_pkg::S_OUT;
                else if (mod_done) n_state = dwvs_pkg::S_BRD;
            end
            dwvs_pkg::S_BRD: n_state = dwvs_pkg::S_BCHK;
            dwvs_pkg::S_BCHK: begin
                if (w_next_b >= {1'b0, r_target}) n_state = dwvs_pkg::S_VRD;
                else if (r_blk == '1) n_state = dwvs_pkg::S_OUT;
                else n_state = dwvs_pkg::S_BRD;
            end
            dwvs_pkg::S_VRD: n_state = dwvs_pkg::S_VCHK;
            dwvs_pkg::S_VCHK: begin
                if (w_next_v >= {1'b0, r_target} || r_off == '1) n_state = dwvs_pkg::S_OUT;
                else n_state = dwvs_pkg::S_VRD;
            end
            dwvs_pkg::S_OUT: if (m_axis_tready) n_state = dwvs_pkg::S_IDLE;
            default: n_state = dwvs_pkg::S_IDLE;
        endcase
    end

    // Memory addresses and strobes.
    always_comb begin
        v_addr    = r_lo;
        b_addr    = r_lo[VW-1:dwvs_pkg::OW];
        v_we      = 1'b0;
        b_we      = 1'b0;
        unique case (r_state)
            dwvs_pkg::S_ADD_WA: begin
                v_we = 1'b1;
                b_we = 1'b1;
            end
            // The read of the second endpoint follows the first write, so a
            // shared block sum is read with its first increment already in.
            dwvs_pkg::S_ADD_RB, dwvs_pkg::S_ADD_WB: begin
                v_addr = r_hi;
                b_addr = r_hi[VW-1:dwvs_pkg::OW];
                v_we   = (r_state == dwvs_pkg::S_ADD_WB);
                b_we   = (r_state == dwvs_pkg::S_ADD_WB);
            end
            dwvs_pkg::S_DIV, dwvs_pkg::S_BRD, dwvs_pkg::S_BCHK: b_addr = r_blk;
            dwvs_pkg::S_VRD, dwvs_pkg::S_VCHK: v_addr = {r_blk, r_off};
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dwvs_pkg::S_IDLE;
            r_total <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == dwvs_pkg::S_ADD_WA) r_total <= r_total + 32'd2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mod_start <= 1'b0;
        if (w_acc) begin
            r_rnd   <= s_axis_tdata[87:24];
            r_added <= 1'b0;
            r_pick  <= '0;
            r_status <= dwvs_pkg::ST_OK;
            r_run   <= '0;
            r_blk   <= '0;
            r_off   <= '0;
            if (s_axis_tuser) begin
                r_lo <= '0;
                r_hi <= '0;
                r_mod_start <= 1'b1;
            end else if (a_in < b_in) begin
                r_lo <= a_in;
                r_hi <= b_in;
            end else begin
                r_lo <= b_in;
                r_hi <= a_in;
            end
        end
        unique case (r_state)
            dwvs_pkg::S_ADD_RD:
                if (r_lo != r_hi && r_total > 32'hFFFF_FFFD) r_status <= dwvs_pkg::ST_FULL;
            dwvs_pkg::S_ADD_WA: r_added <= 1'b1;
            dwvs_pkg::S_DIV: begin
                if (r_total == '0) r_status <= dwvs_pkg::ST_EMPTY;
                if (mod_done) r_target <= mod_rem;
            end
            dwvs_pkg::S_BCHK: begin
                if (w_next_b >= {1'b0, r_target}) begin
                    r_pick <= {r_blk, {dwvs_pkg::OW{1'b0}}};
                end else begin
                    r_run <= w_next_b;
                    r_blk <= r_blk + 1'b1;
                    if (r_blk == '1) r_status <= dwvs_pkg::ST_FAIL;
                end
            end
            dwvs_pkg::S_VCHK: begin
                r_run <= w_next_v;
                if (w_next_v >= {1'b0, r_target}) r_pick <= {r_blk, r_off};
                else if (r_off == '1) r_status <= dwvs_pkg::ST_FAIL;
                else r_off <= r_off + 1'b1;
            end
            default: ;
        endcase
    end

`ifndef SYNTH
    a_one_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("busy while result waits");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_total_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_total[0]) else $error("total odd");
`endif
endmodule
